// ----- rtl/utf8_line_decoder_assert.svh -----
// Assertion macros shared by the utf8 line decoder RTL.
// Clocked on clk, disabled while rst is high; no other dependencies.
`ifndef UTF8_LINE_DECODER_ASSERT_SVH
`define UTF8_LINE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// combinational property checked every cycle out of reset
`define UTF8LD_ASSERT_NOW(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("utf8ld assertion failed");

// antecedent this cycle, consequent on the next
`define UTF8LD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8ld assertion failed");

`else

`define UTF8LD_ASSERT_NOW(label, prop)
`define UTF8LD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/utf8ld_pkg.sv -----
// Types and constants for the utf8 line decoder.
// No dependencies; imported by every RTL module of the block.
package utf8ld_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CpW         = 21;
  localparam int OutCntW     = 16;
  localparam int ExtCntW     = (COUNT_WIDTH > OutCntW) ? COUNT_WIDTH : OutCntW;
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  localparam logic [7:0] TermReset = 8'h0A;
  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;

  typedef enum logic [2:0] {
    ST_CHAR    = 3'd0,
    ST_LINE    = 3'd1,
    ST_BADLEAD = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_EOF     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    LEAD_BAD = 3'd0,
    LEAD_1   = 3'd1,
    LEAD_2   = 3'd2,
    LEAD_3   = 3'd3,
    LEAD_4   = 3'd4
  } lead_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_done;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0]     char_value;
    status_t            status;
    logic [OutCntW-1:0] chars_in_line;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic       done;
    logic       is_term;
    lead_t      lead;
    logic [6:0] lead_bits;
    logic [5:0] cont_bits;
  } cls_t;

endpackage

// ----- rtl/utf8_line_decoder.sv -----
// A byte accepted into the request queue is popped from it by the back end, and its result is
// written to the result register. Throughput: one byte per cycle while res_stall is low;
// a four-entry request queue lets input keep flowing while a result waits.
// Reset (synchronous, rst high): queue empty, no result, idle at lead position,
// line count zero, line_terminator back to 0x0A.
// Top level of the utf8 line decoder; depends on utf8ld_pkg, front, queue and back modules.
module utf8_line_decoder (
  input  logic                  clk,
  input  logic                  rst,
  // byte stream in
  input  logic                  src_valid,
  output logic                  src_stall,
  input  utf8ld_pkg::in_item_t  src_item,
  // decoded results out
  output logic                  res_valid,
  input  logic                  res_stall,
  output utf8ld_pkg::out_item_t res_item,
  // line_terminator write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import utf8ld_pkg::*;

  cls_t cls;
  cls_t q_head;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic push;

  // register writes always land; the user must write only while the block is idle (not enforced)
  assign cfg_ready = 1'b1;

  // stall only on a full queue, so a pending result never blocks intake directly
  assign src_stall = q_full;
  assign push      = src_valid && !q_full;

  // front: terminator compare and lead-range decode, done once per request
  utf8ld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .src_item  (src_item),
    .cls       (cls)
  );

  utf8ld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // back: continuation accumulation, line count, output register
  utf8ld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

endmodule

// ----- rtl/utf8ld_front.sv -----
// Front end: takes input requests, holds line_terminator, classifies bytes.
// Depends on utf8ld_pkg.
module utf8ld_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  utf8ld_pkg::in_item_t src_item,
  output utf8ld_pkg::cls_t    cls
);
  import utf8ld_pkg::*;

  logic [7:0] line_terminator;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_terminator <= TermReset;
    end else if (cfg_valid) begin
      line_terminator <= cfg_data;
    end
  end

  assign b = src_item.data_byte;

  always_comb begin
    cls.done      = src_item.stream_done;
    cls.is_term   = (b == line_terminator);
    cls.cont_bits = b[5:0];
    priority if (b <= AsciiMax) begin
      cls.lead      = LEAD_1;
      cls.lead_bits = b[6:0];
    end else if (b >= Lead2Min && b <= Lead2Max) begin
      cls.lead      = LEAD_2;
      cls.lead_bits = {2'b00, b[4:0]};
    end else if (b >= Lead3Min && b <= Lead3Max) begin
      cls.lead      = LEAD_3;
      cls.lead_bits = {3'b000, b[3:0]};
    end else if (b >= Lead4Min && b <= Lead4Max) begin
      cls.lead      = LEAD_4;
      cls.lead_bits = {4'b0000, b[2:0]};
    end else begin
      cls.lead      = LEAD_BAD;
      cls.lead_bits = '0;
    end
  end

endmodule

// ----- rtl/utf8ld_queue.sv -----
// Short FIFO of classified requests between front and back.
// Depends on utf8ld_pkg and utf8_line_decoder_assert.svh.
`include "utf8_line_decoder_assert.svh"

module utf8ld_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utf8ld_pkg::cls_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output utf8ld_pkg::cls_t head
);
  import utf8ld_pkg::*;

  cls_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] cnt;

  assign full     = (cnt == QCntW'(QDepth));
  assign nonempty = (cnt != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `UTF8LD_ASSERT_NOW(a_cnt_bound, cnt <= QCntW'(QDepth))
  `UTF8LD_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt == $past(cnt) + 1'b1)

endmodule

// ----- rtl/utf8ld_back.sv -----
// Back end: sequence state, line count and the registered result stage.
// Depends on utf8ld_pkg and utf8_line_decoder_assert.svh.
`include "utf8_line_decoder_assert.svh"

module utf8ld_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_nonempty,
  input  utf8ld_pkg::cls_t      q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output utf8ld_pkg::out_item_t res_item
);
  import utf8ld_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [1:0]             rem, rem_next;
  logic [CpW-1:0]         partial, partial_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [ExtCntW-1:0]     count_ext;
  logic [ExtCntW-1:0]     inc_ext;
  logic [CpW-1:0]         shifted;
  logic                   take;
  logic                   emit;
  logic                   closing;
  out_item_t              res_next;

  assign take      = !res_valid || !res_stall;
  assign q_pop     = q_nonempty && take;
  assign count_inc = (count != CntMax) ? count + 1'b1 : count;
  assign count_ext = ExtCntW'(count);
  assign inc_ext   = ExtCntW'(count_inc);
  assign shifted   = {partial[CpW-7:0], q_head.cont_bits};

  always_comb begin
    rem_next     = rem;
    partial_next = partial;
    count_next   = count;
    emit         = 1'b0;
    closing      = 1'b0;
    res_next.char_value    = '0;
    res_next.status        = ST_CHAR;
    res_next.chars_in_line = count_ext[OutCntW-1:0];
    priority if (q_head.done) begin
      emit    = 1'b1;
      closing = 1'b1;
      res_next.status = (rem != 2'd0) ? ST_TRUNC : ST_EOF;
    end else if (rem != 2'd0) begin
      rem_next     = rem - 1'b1;
      partial_next = shifted;
      if (rem == 2'd1) begin
        emit         = 1'b1;
        partial_next = '0;
        count_next   = count_inc;
        res_next.char_value    = shifted;
        res_next.chars_in_line = inc_ext[OutCntW-1:0];
      end
    end else if (q_head.is_term) begin
      emit    = 1'b1;
      closing = 1'b1;
      res_next.status = ST_LINE;
    end else begin
      unique case (q_head.lead)
        LEAD_1: begin
          emit       = 1'b1;
          count_next = count_inc;
          res_next.char_value    = CpW'(q_head.lead_bits);
          res_next.chars_in_line = inc_ext[OutCntW-1:0];
        end
        LEAD_2: begin
          rem_next     = 2'd1;
          partial_next = CpW'(q_head.lead_bits);
        end
        LEAD_3: begin
          rem_next     = 2'd2;
          partial_next = CpW'(q_head.lead_bits);
        end
        LEAD_4: begin
          rem_next     = 2'd3;
          partial_next = CpW'(q_head.lead_bits);
        end
        default: begin
          emit    = 1'b1;
          closing = 1'b1;
          res_next.status = ST_BADLEAD;
        end
      endcase
    end
    if (closing) begin
      rem_next     = 2'd0;
      partial_next = '0;
      count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= 2'd0;
      partial   <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        rem     <= rem_next;
        partial <= partial_next;
        count   <= count_next;
      end
      if (take) begin
        res_valid <= q_pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res_item <= res_next;
    end
  end

  `UTF8LD_ASSERT_NOW(a_close_no_cp,
      !res_valid || res_item.status == ST_CHAR || res_item.char_value == '0)
  `UTF8LD_ASSERT_NEXT(a_close_clears, q_pop && closing, count == '0 && rem == 2'd0)

endmodule
